/* hw/rtl/set_associative_lru_cache_model_top_assert.svh */
// Assertion macros for the set-associative LRU cache model.
// Used by set_associative_lru_cache_model_top; needs clock and reset in scope.
`ifndef SET_ASSOCIATIVE_LRU_CACHE_MODEL_TOP_ASSERT_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_MODEL_TOP_ASSERT_SVH

`define SLRU_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cache assertion failed in the same cycle");

`define SLRU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cache assertion failed in the next cycle");

`endif

/* hw/rtl/slru_pkg.sv */
// Package for the set-associative LRU cache model: sizes, codes and payload types.
// Used by slru_way_sel and set_associative_lru_cache_model_top; depends on nothing.
`timescale 1ns / 1ps

package slru_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;

   localparam int SETS       = 1 << MAX_SET_BITS;
   localparam int SET_W      = MAX_SET_BITS;
   localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAYCNT_W   = $clog2(MAX_WAYS + 1);
   localparam int SB_W       = $clog2(MAX_SET_BITS + 1);
   localparam int TAG_W      = 62;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int ADDR_W     = 64;
   localparam int BB_W       = 6;
   localparam int BB_MAX     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_STORE  = 2'd1,
      ACT_MODIFY = 2'd2,
      ACT_FETCH  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_BLOCK_BITS = 2'd1,
      CSR_WAYS       = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      action_type        action;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      outcome_type        outcome;
      logic               extra_hit;
      logic [COUNT_W-1:0] total_hits;
      logic [COUNT_W-1:0] total_misses;
      logic [COUNT_W-1:0] total_evictions;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] last_use;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic             free;
      logic [WAY_W-1:0] victim;
   } sel_type;

endpackage

/* hw/rtl/slru_way_sel.sv */
// Way selection for one cache set: tag match and least-recently-used victim choice.
// Depends on slru_pkg.
`timescale 1ns / 1ps

module slru_way_sel import slru_pkg::*; (
   input  row_type              row,
   input  logic [TAG_W-1:0]     tag,
   input  logic [WAYCNT_W-1:0]  ways_used,
   output sel_type              sel
);

   logic [TIME_W-1:0] best_use;

   always_comb begin
      sel      = '0;
      best_use = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (!sel.hit && (w < int'(ways_used)) && row[w].valid && (row[w].tag == tag)) begin
            sel.hit     = 1'b1;
            sel.hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if ((w < int'(ways_used)) && !sel.free) begin
            if (!row[w].valid) begin
               sel.free   = 1'b1;
               sel.victim = WAY_W'(w);
            end else if ((w == 0) || (row[w].last_use < best_use)) begin
               sel.victim = WAY_W'(w);
               best_use   = row[w].last_use;
            end
         end
      end
   end

endmodule

/* hw/rtl/set_associative_lru_cache_model_top.sv */
// A data access reads the set's row from the single-port set memory into a register
// when it is taken; the lookup state then compares the configured ways, picks the
// LRU victim, writes the row back and loads the result register. An instruction
// fetch gives no result. A new access is taken only once the previous row write
// is done, and the lookup state waits while an untaken result holds the output.
// Depends on slru_pkg, slru_way_sel and set_associative_lru_cache_model_top_assert.svh.
`timescale 1ns / 1ps

module set_associative_lru_cache_model_top import slru_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "set_associative_lru_cache_model_top_assert.svh"

   state_type state_ff, state_in;

   logic [2:0]          set_bits_ff;
   logic [BB_W-1:0]     block_bits_ff;
   logic [3:0]          ways_ff;
   logic [TIME_W-1:0]   access_clock_ff;
   logic [SET_W-1:0]    set_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic                modify_ff;
   logic [WAYCNT_W-1:0] ways_used_ff;
   logic [SETS-1:0]     row_valid_ff;
   row_type             rd_row_ff;
   logic                rd_rowv_ff;
   logic [COUNT_W-1:0]  hits_ff, misses_ff, evict_ff;
   logic [COUNT_W-1:0]  hits_in, misses_in, evict_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   row_type             mem [SETS];

   logic [SB_W-1:0]     sb_c;
   logic [BB_W-1:0]     bb_c;
   logic [WAYCNT_W-1:0] ways_c;
   logic [ADDR_W-1:0]   shifted;
   logic [SET_W-1:0]    set_idx;
   logic [TAG_W-1:0]    tag_c;
   logic                accept;
   logic                data_accept;
   logic                lookup_go;
   row_type             row_masked;
   row_type             row_new;
   sel_type             sel;
   logic [1:0]          hit_add;
   logic [COUNT_W:0]    hit_sum;
   outcome_type         outcome_c;

   always_comb begin
      if (set_bits_ff == '0) begin
         sb_c = SB_W'(1);
      end else if (32'(set_bits_ff) > MAX_SET_BITS) begin
         sb_c = SB_W'(MAX_SET_BITS);
      end else begin
         sb_c = SB_W'(set_bits_ff);
      end
      if (block_bits_ff == '0) begin
         bb_c = BB_W'(1);
      end else if (32'(block_bits_ff) > BB_MAX) begin
         bb_c = BB_W'(BB_MAX);
      end else begin
         bb_c = block_bits_ff;
      end
      if (ways_ff == '0) begin
         ways_c = WAYCNT_W'(1);
      end else if (32'(ways_ff) > MAX_WAYS) begin
         ways_c = WAYCNT_W'(MAX_WAYS);
      end else begin
         ways_c = WAYCNT_W'(ways_ff);
      end
      shifted = req_data.address >> bb_c;
      set_idx = SET_W'(shifted & ((ADDR_W'(1) << sb_c) - ADDR_W'(1)));
      tag_c   = TAG_W'(shifted >> sb_c);
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            if (data_accept) begin
               state_in = ST_LOOKUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            if (lookup_go) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      lookup_go   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_LOOKUP: lookup_go = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            lookup_go = 1'b0;
         end
      endcase
      accept      = req_valid && req_ready;
      data_accept = accept && (req_data.action != ACT_FETCH);
      csr_ready   = 1'b1;
      rsp_valid   = rsp_valid_ff;
      rsp_data    = rsp_data_ff;
   end

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         row_masked[w]       = rd_row_ff[w];
         row_masked[w].valid = rd_row_ff[w].valid && rd_rowv_ff;
      end
   end

   slru_way_sel u_way_sel (
      .row       (row_masked),
      .tag       (tag_ff),
      .ways_used (ways_used_ff),
      .sel       (sel)
   );

   always_comb begin
      row_new = row_masked;
      if (sel.hit) begin
         row_new[sel.hit_way].last_use = access_clock_ff;
      end else begin
         row_new[sel.victim].valid    = 1'b1;
         row_new[sel.victim].tag      = tag_ff;
         row_new[sel.victim].last_use = access_clock_ff;
      end
      hit_add   = {1'b0, sel.hit} + {1'b0, modify_ff};
      hit_sum   = {1'b0, hits_ff} + (COUNT_W + 1)'(hit_add);
      hits_in   = hit_sum[COUNT_W] ? '1 : hit_sum[COUNT_W-1:0];
      misses_in = misses_ff;
      evict_in  = evict_ff;
      if (!sel.hit && (misses_ff != '1)) begin
         misses_in = misses_ff + COUNT_W'(1);
      end
      if (!sel.hit && !sel.free && (evict_ff != '1)) begin
         evict_in = evict_ff + COUNT_W'(1);
      end
      if (sel.hit) begin
         outcome_c = OUT_HIT;
      end else if (sel.free) begin
         outcome_c = OUT_FILL;
      end else begin
         outcome_c = OUT_EVICT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         set_bits_ff     <= 3'd4;
         block_bits_ff   <= BB_W'(4);
         ways_ff         <= 4'd1;
         access_clock_ff <= '0;
         row_valid_ff    <= '0;
         hits_ff         <= '0;
         misses_ff       <= '0;
         evict_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[BB_W-1:0];
               CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (accept) begin
            access_clock_ff <= access_clock_ff + TIME_W'(1);
         end
         if (lookup_go) begin
            row_valid_ff[set_ff] <= 1'b1;
            hits_ff              <= hits_in;
            misses_ff            <= misses_in;
            evict_ff             <= evict_in;
            rsp_valid_ff         <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (data_accept) begin
         set_ff       <= set_idx;
         tag_ff       <= tag_c;
         modify_ff    <= (req_data.action == ACT_MODIFY);
         ways_used_ff <= ways_c;
         rd_rowv_ff   <= row_valid_ff[set_idx];
      end
      if (lookup_go) begin
         rsp_data_ff.outcome         <= outcome_c;
         rsp_data_ff.extra_hit       <= modify_ff;
         rsp_data_ff.total_hits      <= hits_in;
         rsp_data_ff.total_misses    <= misses_in;
         rsp_data_ff.total_evictions <= evict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (data_accept) begin
         rd_row_ff <= mem[set_idx];
      end
      if (lookup_go) begin
         mem[set_ff] <= row_new;
      end
   end

   `SLRU_ASSERT_NEXT(a_data_goes_lookup, data_accept, state_ff == ST_LOOKUP)
   `SLRU_ASSERT_NEXT(a_clock_advances, accept,
      access_clock_ff == $past(access_clock_ff) + TIME_W'(1))
   `SLRU_ASSERT_NOW(a_evict_counted,
      rsp_valid_ff && (rsp_data_ff.outcome == OUT_EVICT), rsp_data_ff.total_evictions != '0)
   `SLRU_ASSERT_NOW(a_miss_counted,
      rsp_valid_ff && (rsp_data_ff.outcome != OUT_HIT), rsp_data_ff.total_misses != '0)

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for set_associative_lru_cache_model_top: directed and random
// accesses under several geometries, checked against an LRU cache predictor.
// Depends on slru_pkg and the set_associative_lru_cache_model_top RTL.
`timescale 1ns / 1ps

module tb_top;
   import slru_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int LINES          = SETS * MAX_WAYS;
   localparam int PHASES         = 8;
   localparam int PHASE_ACCESSES = 100;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TABLE_ROWS     = 15;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type result;
   } access_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [2:0]         set_bits_reg   = 3'd4;
   logic [5:0]         block_bits_reg = 6'd4;
   logic [3:0]         ways_reg       = 4'd1;
   logic               line_valid [LINES] = '{default: 1'b0};
   logic [TAG_W-1:0]   line_tag [LINES];
   logic [TIME_W-1:0]  line_stamp [LINES];
   logic [TIME_W-1:0]  access_tick    = '0;
   logic [COUNT_W-1:0] hit_count      = '0;
   logic [COUNT_W-1:0] miss_count     = '0;
   logic [COUNT_W-1:0] eviction_count = '0;

   rsp_type expected_outcomes [$];
   int      error_count     = 0;
   int      responses_taken = 0;
   int      quiet_cycles    = 0;
   logic    idle_on         = 1'b1;

   access_row_type access_table [TABLE_ROWS] = '{
      '{'{ACT_LOAD,   64'h0}, 1'b1, '{OUT_FILL,  1'b0, 32'd0, 32'd1, 32'd0}},
      '{'{ACT_LOAD,   64'h0}, 1'b1, '{OUT_HIT,   1'b0, 32'd1, 32'd1, 32'd0}},
      '{'{ACT_STORE,  64'hF}, 1'b1, '{OUT_HIT,   1'b0, 32'd2, 32'd1, 32'd0}},
      '{'{ACT_MODIFY, 64'h100}, 1'b1, '{OUT_EVICT, 1'b1, 32'd3, 32'd2, 32'd1}},
      '{'{ACT_FETCH,  64'h100}, 1'b0, '0},
      '{'{ACT_LOAD,   64'h0}, 1'b1, '{OUT_EVICT, 1'b0, 32'd3, 32'd3, 32'd2}},
      '{'{ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{OUT_FILL, 1'b0, 32'd3, 32'd4, 32'd2}},
      '{'{ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{OUT_HIT, 1'b1, 32'd5, 32'd4, 32'd2}},
      '{'{ACT_STORE,  64'hFFFF_FFFF_FFFF_FF0F}, 1'b1, '{OUT_EVICT, 1'b0, 32'd5, 32'd5, 32'd3}},
      '{'{ACT_LOAD,   64'h10}, 1'b1, '{OUT_FILL,  1'b0, 32'd5, 32'd6, 32'd3}},
      '{'{ACT_FETCH,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0},
      '{'{ACT_LOAD,   64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
      '{'{ACT_STORE,  64'h5555_5555_5555_5555}, 1'b0, '0},
      '{'{ACT_MODIFY, 64'h8000_0000_0000_0000}, 1'b0, '0},
      '{'{ACT_LOAD,   64'h7FFF_FFFF_FFFF_FFFF}, 1'b0, '0}
   };

   set_associative_lru_cache_model_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned clamp_field(input int unsigned value, input int unsigned lo,
                                               input int unsigned hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   function automatic logic lookup_cache(input req_type item, output rsp_type result);
      int unsigned      sb;
      int unsigned      bb;
      int unsigned      ways;
      int unsigned      base;
      int unsigned      victim;
      logic [TAG_W-1:0] tag;
      logic             found;
      logic             free_way;
      access_tick = access_tick + 1'b1;
      result = '0;
      if (item.action == ACT_FETCH) return 1'b0;
      sb = clamp_field(set_bits_reg, 1, MAX_SET_BITS);
      bb = clamp_field(block_bits_reg, 1, BB_MAX);
      ways = clamp_field(ways_reg, 1, MAX_WAYS);
      base = int'((item.address >> bb) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
      tag = TAG_W'(item.address >> (bb + sb));
      found = 1'b0;
      free_way = 1'b0;
      victim = 0;
      for (int w = 0; w < ways; w++) begin
         if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
            found = 1'b1;
            line_stamp[base + w] = access_tick;
         end
      end
      if (found) begin
         result.outcome = OUT_HIT;
         hit_count = bump_count(hit_count);
      end else begin
         for (int w = 0; w < ways; w++) begin
            if (!free_way) begin
               if (!line_valid[base + w]) begin
                  victim = w;
                  free_way = 1'b1;
               end else if (w == 0 || line_stamp[base + w] < line_stamp[base + victim]) begin
                  victim = w;
               end
            end
         end
         miss_count = bump_count(miss_count);
         if (free_way) begin
            result.outcome = OUT_FILL;
         end else begin
            result.outcome = OUT_EVICT;
            eviction_count = bump_count(eviction_count);
         end
         line_valid[base + victim] = 1'b1;
         line_tag[base + victim] = tag;
         line_stamp[base + victim] = access_tick;
      end
      if (item.action == ACT_MODIFY) hit_count = bump_count(hit_count);
      result.extra_hit = (item.action == ACT_MODIFY);
      result.total_hits = hit_count;
      result.total_misses = miss_count;
      result.total_evictions = eviction_count;
      return 1'b1;
   endfunction

   task automatic send_access(input req_type item, input logic typed, input rsp_type typed_result);
      int unsigned gap;
      rsp_type     predicted;
      gap = idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (lookup_cache(item, predicted)) begin
         expected_outcomes.push_back(typed ? typed_result : predicted);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SET_BITS:   set_bits_reg = value[2:0];
         CSR_BLOCK_BITS: block_bits_reg = value[5:0];
         CSR_WAYS:       ways_reg = value[3:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(input logic [2:0] sb, input logic [5:0] bb, input logic [3:0] ways);
      write_csr(CSR_SET_BITS, CSR_DATA_W'(sb));
      write_csr(CSR_BLOCK_BITS, bb);
      write_csr(CSR_WAYS, CSR_DATA_W'(ways));
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 63)));
      csr_valid <= 1'b0;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_outcomes.size() != 0);
   endtask

   initial begin : stimulus
      req_type           item;
      logic [ADDR_W-1:0] hot_tag;
      logic [ADDR_W-1:0] offset;
      int unsigned       sb;
      int unsigned       bb;
      int unsigned       ways;
      int                sent;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int row = 0; row < TABLE_ROWS; row++) begin
         send_access(access_table[row].item, access_table[row].typed, access_table[row].result);
      end
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_responses();
         repeat (SETTLE_CYCLES) @(negedge clock);
         case (phase)
            0: configure(3'd0, 6'd0, 4'd0);
            1: configure(3'd7, 6'd63, 4'd15);
            2: configure(3'd6, 6'd32, 4'd8);
            3: configure(3'd1, 6'd1, 4'd8);
            4: configure(3'd1, 6'd32, 4'd2);
            5: configure(3'd3, 6'd5, 4'd4);
            default: configure(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                               4'($urandom_range(0, 15)));
         endcase
         idle_on = (phase % 3 != 1);
         sb = clamp_field(set_bits_reg, 1, MAX_SET_BITS);
         bb = clamp_field(block_bits_reg, 1, BB_MAX);
         ways = clamp_field(ways_reg, 1, MAX_WAYS);
         hot_tag = {$urandom, $urandom};
         sent = 0;
         while (sent < PHASE_ACCESSES) begin
            item.action = action_type'(2'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) < 2) begin
               item.address = {$urandom, $urandom};
            end else begin
               // A handful of tags over a few sets keeps hits and evictions frequent.
               offset = {$urandom, $urandom};
               item.address = ((hot_tag ^ ADDR_W'($urandom_range(0, ways + 2))) << (bb + sb))
                              | (ADDR_W'($urandom_range(0, 3)) << bb)
                              | (offset & ((64'd1 << bb) - 64'd1));
            end
            send_access(item, 1'b0, '0);
            sent++;
            if (phase == 3 && sent == PHASE_ACCESSES / 2) drain_responses();
         end
      end
      drain_responses();
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin : response_sink
      int unsigned gap;
      logic        long_hold_done;
      long_hold_done = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         gap = idle_on ? $urandom_range(0, 16) : 0;
         if (!long_hold_done && responses_taken >= 150) begin
            gap = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_taken <= responses_taken + 1;
         if (expected_outcomes.size() == 0) begin
            $error("unexpected transfer: outcome %0d", rsp_data.outcome);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_data.outcome !== want.outcome) begin
               $error("outcome: expected %0d, actual %0d", want.outcome, rsp_data.outcome);
               error_count++;
            end
            if (rsp_data.extra_hit !== want.extra_hit) begin
               $error("extra_hit: expected %0d, actual %0d", want.extra_hit, rsp_data.extra_hit);
               error_count++;
            end
            if (rsp_data.total_hits !== want.total_hits) begin
               $error("total_hits: expected %0d, actual %0d", want.total_hits,
                      rsp_data.total_hits);
               error_count++;
            end
            if (rsp_data.total_misses !== want.total_misses) begin
               $error("total_misses: expected %0d, actual %0d", want.total_misses,
                      rsp_data.total_misses);
               error_count++;
            end
            if (rsp_data.total_evictions !== want.total_evictions) begin
               $error("total_evictions: expected %0d, actual %0d", want.total_evictions,
                      rsp_data.total_evictions);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/slru_pkg.sv
hw/rtl/slru_way_sel.sv
hw/rtl/set_associative_lru_cache_model_top.sv
verif/tb_top.sv
